// ===== sv/h264fu_pkg.sv =====
// Shared types and constants for the H.264 RTP FU-A packetiser.
package h264fu_pkg;

  // Field widths.
  localparam int MTU_W   = 14;
  localparam int SEQ_W   = 16;
  localparam int LEN_W   = 16;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Packet geometry.
  localparam int RTP_HDR_BYTES = 12;
  localparam int FU_HDR_BYTES  = 2;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MTU = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEQ = 1'b1;

  // Configuration reset values.
  localparam logic [MTU_W-1:0] MTU_RESET = 14'd1400;
  localparam logic [MTU_W-1:0] PAY_RESET = 14'(1400 - RTP_HDR_BYTES - FU_HDR_BYTES);
  localparam logic [SEQ_W-1:0] SEQ_RESET = 16'd0;

  // NAL unit types and FU-A byte fields.
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_AUD = 5'd9;
  localparam logic [7:0] FU_A_TYPE = 8'h1C;
  localparam logic [7:0] NRI_MASK  = 8'h60;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_S_BIT  = 8'h80;
  localparam logic [7:0] FU_E_BIT  = 8'h40;

  // One classified input byte: up to three output transactions.
  typedef struct packed {
    logic               has_hdr;     // indicator and FU header go first
    logic               has_data;    // the input byte itself goes out
    logic               fu_end;      // packet_end on the FU header
    logic               data_start;  // packet_start on the data byte
    logic               data_end;    // packet_end on the data byte
    logic [7:0]         ind_byte;
    logic [7:0]         fu_byte;
    logic [7:0]         data_byte;
    logic [SEQ_W-1:0]   seq;
    logic               marker;
    logic [STAMP_W-1:0] stamp;
  } job_t;

endpackage

// ===== sv/h264fu_front.sv =====
// Front end: holds unit state and configuration, classifies each byte into a job.
module h264fu_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [h264fu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [h264fu_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_nal_first,
  input  logic [h264fu_pkg::LEN_W-1:0]         in_nal_length,
  input  logic [h264fu_pkg::STAMP_W-1:0]       in_stamp_in,
  input  logic                                 q_full,
  output logic                                 push,
  output h264fu_pkg::job_t                     job
);

  typedef enum logic [1:0] {
    MODE_DROP   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_FRAG   = 2'd2
  } mode_t;

  logic [h264fu_pkg::MTU_W-1:0]   mtu_r;
  logic [h264fu_pkg::MTU_W-1:0]   pay_r, pay_nxt;
  logic                           wait_sps_r, wait_sps_nxt;
  logic [h264fu_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic [h264fu_pkg::LEN_W-1:0]   offset_r, offset_nxt;
  logic [h264fu_pkg::LEN_W-1:0]   ulen_r, ulen_nxt;
  logic [7:0]                     hdr_r, hdr_nxt;
  mode_t                          mode_r, mode_nxt;
  logic [h264fu_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic                           marker_r, marker_nxt;
  logic [h264fu_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;

  logic                           accept;
  logic [4:0]                     nal_type;
  logic [h264fu_pkg::LEN_W-1:0]   len1;
  logic                           single_ok;
  logic [h264fu_pkg::LEN_W-1:0]   rem;
  logic [h264fu_pkg::LEN_W-1:0]   pay16;
  logic [h264fu_pkg::LEN_W-1:0]   chunk;
  logic                           ends;
  logic [7:0]                     hdr_src;
  logic [7:0]                     ind_b;
  logic [7:0]                     fu_b;
  logic [h264fu_pkg::LEN_W-1:0]   offset_inc;
  logic [h264fu_pkg::LEN_W-1:0]   left_base;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Fragment payload size follows the MTU, worked out once per write.
  always_comb begin
    if (cfg_wdata[h264fu_pkg::MTU_W-1:0] >=
        h264fu_pkg::MTU_W'(h264fu_pkg::RTP_HDR_BYTES + h264fu_pkg::FU_HDR_BYTES + 1)) begin
      pay_nxt = cfg_wdata[h264fu_pkg::MTU_W-1:0] -
                h264fu_pkg::MTU_W'(h264fu_pkg::RTP_HDR_BYTES + h264fu_pkg::FU_HDR_BYTES);
    end else begin
      pay_nxt = h264fu_pkg::MTU_W'(1);
    end
  end

  // Shared fragment opening arithmetic for header and data bytes.
  always_comb begin
    nal_type   = in_data_byte[4:0];
    len1       = (in_nal_length == '0) ? h264fu_pkg::LEN_W'(1) : in_nal_length;
    single_ok  = ({1'b0, len1} + 17'(h264fu_pkg::RTP_HDR_BYTES)) <=
                 {{(17 - h264fu_pkg::MTU_W){1'b0}}, mtu_r};
    rem        = in_nal_first ? (len1 - h264fu_pkg::LEN_W'(1)) : (ulen_r - offset_r);
    pay16      = {{(h264fu_pkg::LEN_W - h264fu_pkg::MTU_W){1'b0}}, pay_r};
    ends       = (rem <= pay16);
    chunk      = ends ? rem : pay16;
    hdr_src    = in_nal_first ? in_data_byte : hdr_r;
    ind_b      = (hdr_src & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
    fu_b       = (hdr_src & h264fu_pkg::TYPE_MASK)
               | (in_nal_first ? h264fu_pkg::FU_S_BIT : 8'h00)
               | (ends ? h264fu_pkg::FU_E_BIT : 8'h00);
    offset_inc = offset_r + h264fu_pkg::LEN_W'(1);
    left_base  = (left_r == '0) ? chunk : left_r;
  end

  // Classification of the accepted byte and next unit state.
  always_comb begin
    wait_sps_nxt = wait_sps_r;
    seq_nxt      = seq_r;
    offset_nxt   = offset_r;
    ulen_nxt     = ulen_r;
    hdr_nxt      = hdr_r;
    mode_nxt     = mode_r;
    left_nxt     = left_r;
    marker_nxt   = marker_r;
    stamp_nxt    = stamp_r;
    push         = 1'b0;
    job          = '0;
    job.ind_byte  = ind_b;
    job.fu_byte   = fu_b;
    job.data_byte = in_data_byte;

    if (accept) begin
      if (in_nal_first) begin
        mode_nxt = MODE_DROP;
        if (nal_type != h264fu_pkg::NAL_AUD &&
            !(wait_sps_r && nal_type != h264fu_pkg::NAL_SPS)) begin
          wait_sps_nxt = 1'b0;
          ulen_nxt     = len1;
          hdr_nxt      = in_data_byte;
          stamp_nxt    = in_stamp_in;
          offset_nxt   = h264fu_pkg::LEN_W'(1);
          seq_nxt      = seq_r + h264fu_pkg::SEQ_W'(1);
          push         = 1'b1;
          if (single_ok) begin
            // Whole unit fits in one packet.
            marker_nxt     = !(nal_type == h264fu_pkg::NAL_SPS ||
                               nal_type == h264fu_pkg::NAL_PPS);
            job.has_data   = 1'b1;
            job.data_start = 1'b1;
            job.data_end   = (len1 == h264fu_pkg::LEN_W'(1));
            mode_nxt       = (len1 == h264fu_pkg::LEN_W'(1)) ? MODE_DROP : MODE_SINGLE;
          end else begin
            // First fragment: the header byte itself is not sent.
            marker_nxt  = ends;
            left_nxt    = chunk;
            job.has_hdr = 1'b1;
            job.fu_end  = (rem == '0);
            mode_nxt    = (len1 == h264fu_pkg::LEN_W'(1)) ? MODE_DROP : MODE_FRAG;
          end
          job.seq    = seq_nxt;
          job.marker = marker_nxt;
          job.stamp  = in_stamp_in;
        end
      end else begin
        case (mode_r)
          MODE_SINGLE: begin
            offset_nxt   = offset_inc;
            push         = 1'b1;
            job.has_data = 1'b1;
            job.data_end = (offset_inc >= ulen_r);
            if (offset_inc >= ulen_r) begin
              mode_nxt = MODE_DROP;
            end
          end
          MODE_FRAG: begin
            // A data byte with an exhausted fragment opens the next one.
            if (left_r == '0) begin
              seq_nxt     = seq_r + h264fu_pkg::SEQ_W'(1);
              marker_nxt  = ends;
              job.has_hdr = 1'b1;
              job.fu_end  = (rem == '0);
            end
            left_nxt     = left_base - h264fu_pkg::LEN_W'(1);
            offset_nxt   = offset_inc;
            push         = 1'b1;
            job.has_data = 1'b1;
            job.data_end = (left_nxt == '0);
            if (offset_inc >= ulen_r) begin
              mode_nxt = MODE_DROP;
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
        job.seq    = seq_nxt;
        job.marker = marker_nxt;
        job.stamp  = stamp_r;
      end
    end
  end

  // Unit state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r      <= h264fu_pkg::MTU_RESET;
      pay_r      <= h264fu_pkg::PAY_RESET;
      wait_sps_r <= 1'b1;
      seq_r      <= h264fu_pkg::SEQ_RESET;
      offset_r   <= '0;
      ulen_r     <= '0;
      hdr_r      <= '0;
      mode_r     <= MODE_DROP;
      left_r     <= '0;
      marker_r   <= 1'b0;
      stamp_r    <= '0;
    end else begin
      wait_sps_r <= wait_sps_nxt;
      offset_r   <= offset_nxt;
      ulen_r     <= ulen_nxt;
      hdr_r      <= hdr_nxt;
      mode_r     <= mode_nxt;
      left_r     <= left_nxt;
      marker_r   <= marker_nxt;
      stamp_r    <= stamp_nxt;
      seq_r      <= seq_nxt;
      if (cfg_we) begin
        case (cfg_index)
          h264fu_pkg::CFG_IDX_MTU: begin
            mtu_r <= cfg_wdata[h264fu_pkg::MTU_W-1:0];
            pay_r <= pay_nxt;
          end
          h264fu_pkg::CFG_IDX_SEQ: begin
            seq_r <= cfg_wdata[h264fu_pkg::SEQ_W-1:0];
          end
          default: begin
            mtu_r <= mtu_r;
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  // Outside configuration writes the sequence number only ever steps by one.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> (seq_r == $past(seq_r)) || (seq_r == $past(seq_r) + h264fu_pkg::SEQ_W'(1)))
    else $error("sequence number jumped");

  // A job that opens a packet always carries a new sequence number.
  a_seq_new: assert property (@(posedge clk) disable iff (!rst_n)
    push && (job.has_hdr || job.data_start) |-> job.seq == seq_r + h264fu_pkg::SEQ_W'(1))
    else $error("packet opened without a new sequence number");
`endif

endmodule

// ===== sv/h264fu_queue.sv =====
// Short job queue between the classifying front and the output back end.
module h264fu_queue #(
  parameter int DEPTH = h264fu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  h264fu_pkg::job_t  job_in,
  input  logic              pop,
  output h264fu_pkg::job_t  head,
  output logic              head_valid,
  output logic              full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  h264fu_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(DEPTH));

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

`ifndef SYNTH
  // No write into a full queue unless a read goes with it, and no read from an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job queue underflow");
`endif

endmodule

// ===== sv/h264fu_back.sv =====
// Back end: expands each job into payload byte transactions through an output register.
module h264fu_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  h264fu_pkg::job_t                 head,
  input  logic                             head_valid,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_packet_start,
  output logic                             out_packet_end,
  output logic [h264fu_pkg::SEQ_W-1:0]     out_seq_number,
  output logic                             out_marker_bit,
  output logic [h264fu_pkg::STAMP_W-1:0]   out_stamp_out,
  output logic                             out_item_done
);

  typedef enum logic [1:0] {
    PH_IND  = 2'd0,
    PH_FU   = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t                         ph_r, ph_nxt;
  logic                           valid_r;
  logic [7:0]                     byte_r;
  logic                           start_r, end_r, done_r, marker_r;
  logic [h264fu_pkg::SEQ_W-1:0]   seq_r;
  logic [h264fu_pkg::STAMP_W-1:0] stamp_r;

  phase_t                         ph_eff;
  logic [7:0]                     cur_byte;
  logic                           cur_start, cur_end, cur_done, last;
  logic                           load;

  assign load = head_valid && (!valid_r || out_ready);
  assign pop  = load && last;

  // Select the transaction for the current phase of the head job.
  always_comb begin
    ph_eff    = head.has_hdr ? ph_r : PH_DATA;
    cur_byte  = head.data_byte;
    cur_start = head.data_start;
    cur_end   = head.data_end;
    cur_done  = 1'b1;
    last      = 1'b1;
    ph_nxt    = ph_r;
    case (ph_eff)
      PH_IND: begin
        cur_byte  = head.ind_byte;
        cur_start = 1'b1;
        cur_end   = 1'b0;
        cur_done  = 1'b0;
        last      = 1'b0;
      end
      PH_FU: begin
        cur_byte  = head.fu_byte;
        cur_start = 1'b0;
        cur_end   = head.fu_end;
        cur_done  = !head.has_data;
        last      = !head.has_data;
      end
      default: begin
        cur_byte  = head.data_byte;
      end
    endcase
    if (load) begin
      if (last) begin
        ph_nxt = PH_IND;
      end else if (ph_eff == PH_IND) begin
        ph_nxt = PH_FU;
      end else begin
        ph_nxt = PH_DATA;
      end
    end
  end

  // Phase counter and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IND;
      valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (load) begin
        valid_r  <= 1'b1;
        byte_r   <= cur_byte;
        start_r  <= cur_start;
        end_r    <= cur_end;
        done_r   <= cur_done;
        seq_r    <= head.seq;
        marker_r <= head.marker;
        stamp_r  <= head.stamp;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_packet_start = start_r;
  assign out_packet_end   = end_r;
  assign out_seq_number   = seq_r;
  assign out_marker_bit   = marker_r;
  assign out_stamp_out    = stamp_r;
  assign out_item_done    = done_r;

`ifndef SYNTH
  // The phase only leaves the indicator while a fragment header job is at the head.
  a_phase_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_IND) |-> head_valid && head.has_hdr)
    else $error("phase advanced without a fragment header job");
`endif

endmodule

// ===== sv/h264_rtp_fu_packetizer.sv =====
// Top level of the H.264 RTP FU-A packetiser: front, job queue and back end.
// An accepted input byte is written into the job queue, then loaded into the output register.
// Throughput: one byte per cycle for data bytes while the output is ready;
// a byte that opens a fragment yields two or three results through the single output register.
// The job queue (QUEUE_DEPTH entries) absorbs these bursts before the input stalls.
// Reset: synchronous, active low; clears unit state, queue and output, loads register defaults.
module h264_rtp_fu_packetizer #(
  parameter int QUEUE_DEPTH = h264fu_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [h264fu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [h264fu_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_nal_first,
  input  logic [h264fu_pkg::LEN_W-1:0]         in_nal_length,
  input  logic [h264fu_pkg::STAMP_W-1:0]       in_stamp_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 out_packet_start,
  output logic                                 out_packet_end,
  output logic [h264fu_pkg::SEQ_W-1:0]         out_seq_number,
  output logic                                 out_marker_bit,
  output logic [h264fu_pkg::STAMP_W-1:0]       out_stamp_out,
  output logic                                 out_item_done
);

  h264fu_pkg::job_t job_in;
  h264fu_pkg::job_t head;
  logic             push;
  logic             pop;
  logic             head_valid;
  logic             q_full;

  // Byte classification and unit state.
  h264fu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_nal_first  (in_nal_first),
    .in_nal_length (in_nal_length),
    .in_stamp_in   (in_stamp_in),
    .q_full        (q_full),
    .push          (push),
    .job           (job_in)
  );

  // Decoupling queue.
  h264fu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .job_in     (job_in),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // Payload byte sequencing and output register.
  h264fu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_packet_start (out_packet_start),
    .out_packet_end   (out_packet_end),
    .out_seq_number   (out_seq_number),
    .out_marker_bit   (out_marker_bit),
    .out_stamp_out    (out_stamp_out),
    .out_item_done    (out_item_done)
  );

endmodule

// ===== verif/h264_rtp_fu_tb_pkg.sv =====
// Scoreboard for the H.264 RTP FU-A packetiser: byte-level prediction and result checking.
`timescale 1ns / 100ps

package h264_rtp_fu_tb_pkg;
  import h264fu_pkg::*;

  typedef enum logic [1:0] {
    UNIT_DROP  = 2'd0,
    UNIT_WHOLE = 2'd1,
    UNIT_FRAG  = 2'd2
  } unit_mode_e;

  // One payload byte as it leaves the block, with its packet tags.
  typedef struct packed {
    logic [7:0]         data;
    logic               pkt_start;
    logic               pkt_end;
    logic [SEQ_W-1:0]   seq;
    logic               marker;
    logic [STAMP_W-1:0] stamp;
    logic               item_last;
  } payload_beat_t;

  class fu_packet_scoreboard;
    payload_beat_t      due_q[$];
    logic [MTU_W-1:0]   mtu;
    logic [SEQ_W-1:0]   seq_cnt;
    bit                 awaiting_sps;
    unit_mode_e         mode;
    logic [LEN_W-1:0]   taken;
    logic [LEN_W-1:0]   unit_len;
    logic [LEN_W-1:0]   frag_left;
    logic [7:0]         unit_hdr;
    logic               marker;
    logic [STAMP_W-1:0] stamp_hold;
    int                 n_bytes;
    int                 n_beats;
    int                 n_whole;
    int                 n_frags;
    int                 n_fails;

    function new();
      mtu          = MTU_RESET;
      seq_cnt      = SEQ_RESET;
      awaiting_sps = 1'b1;
      mode         = UNIT_DROP;
      taken        = '0;
      unit_len     = '0;
      frag_left    = '0;
      unit_hdr     = '0;
      marker       = 1'b0;
      stamp_hold   = '0;
      n_bytes      = 0;
      n_beats      = 0;
      n_whole      = 0;
      n_frags      = 0;
      n_fails      = 0;
    endfunction

    // A sequence number write also reloads the running counter.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_IDX_MTU: mtu = value[MTU_W-1:0];
        CFG_IDX_SEQ: seq_cnt = value[SEQ_W-1:0];
        default: ;
      endcase
    endfunction

    function void queue_beat(logic [7:0] d, logic s, logic e, logic last);
      payload_beat_t b;
      b.data      = d;
      b.pkt_start = s;
      b.pkt_end   = e;
      b.seq       = seq_cnt;
      b.marker    = marker;
      b.stamp     = stamp_hold;
      b.item_last = last;
      due_q.push_back(b);
    endfunction

    // Starts a new FU-A packet: indicator byte, then the FU header.
    function void open_fragment(bit first_frag, bit hdr_only);
      int unsigned remaining;
      int unsigned pay;
      int unsigned chunk;
      bit          ends;
      logic [7:0]  fu;
      remaining = unit_len - taken;
      pay = (mtu >= RTP_HDR_BYTES + FU_HDR_BYTES + 1) ?
            mtu - RTP_HDR_BYTES - FU_HDR_BYTES : 1;
      chunk = (remaining < pay) ? remaining : pay;
      ends = (chunk == remaining);
      fu = (unit_hdr & TYPE_MASK) | (first_frag ? FU_S_BIT : 8'h00) |
           (ends ? FU_E_BIT : 8'h00);
      seq_cnt   = seq_cnt + 1'b1;
      marker    = ends;
      frag_left = LEN_W'(chunk);
      queue_beat((unit_hdr & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0, 1'b0);
      queue_beat(fu, 1'b0, remaining == 0, hdr_only);
      n_frags++;
    endfunction

    function void predict_byte(logic [7:0] d, logic first, logic [LEN_W-1:0] len_in,
                               logic [STAMP_W-1:0] stamp_in);
      logic [4:0]       nal_type;
      logic [LEN_W-1:0] len;
      nal_type = d[4:0];
      if (first) begin
        mode = UNIT_DROP;
        if (nal_type == NAL_AUD) return;
        if (awaiting_sps && nal_type != NAL_SPS) return;
        awaiting_sps = 1'b0;
        len        = (len_in == 0) ? LEN_W'(1) : len_in;
        unit_len   = len;
        unit_hdr   = d;
        stamp_hold = stamp_in;
        taken      = LEN_W'(1);
        if (int'(len) <= int'(mtu) - RTP_HDR_BYTES) begin
          // Whole unit in one packet; parameter sets carry no marker.
          seq_cnt = seq_cnt + 1'b1;
          marker  = !(nal_type == NAL_SPS || nal_type == NAL_PPS);
          queue_beat(d, 1'b1, len == 1, 1'b1);
          n_whole++;
          mode = (len == 1) ? UNIT_DROP : UNIT_WHOLE;
        end else begin
          mode = (len == 1) ? UNIT_DROP : UNIT_FRAG;
          open_fragment(1'b1, 1'b1);
        end
        return;
      end
      case (mode)
        UNIT_WHOLE: begin
          taken = taken + 1'b1;
          queue_beat(d, 1'b0, taken >= unit_len, 1'b1);
          if (taken >= unit_len) mode = UNIT_DROP;
        end
        UNIT_FRAG: begin
          // A data byte that finds the fragment used up opens the next one.
          if (frag_left == 0) open_fragment(1'b0, 1'b0);
          frag_left = frag_left - 1'b1;
          taken     = taken + 1'b1;
          queue_beat(d, 1'b0, frag_left == 0, 1'b1);
          if (taken >= unit_len) mode = UNIT_DROP;
        end
        default: ;
      endcase
    endfunction

    // Notes an accepted input transaction; returns how many results it causes.
    function int note_input(logic [7:0] d, logic first, logic [LEN_W-1:0] len_in,
                            logic [STAMP_W-1:0] stamp_in);
      int before_n;
      before_n = due_q.size();
      n_bytes++;
      predict_byte(d, first, len_in, stamp_in);
      return due_q.size() - before_n;
    endfunction

    function string show(payload_beat_t b);
      return $sformatf("byte %02h start %b end %b seq %04h marker %b stamp %08h last %b",
                       b.data, b.pkt_start, b.pkt_end, b.seq, b.marker, b.stamp,
                       b.item_last);
    endfunction

    // Compares one output transaction with the oldest expectation.
    function void check_result(payload_beat_t got);
      payload_beat_t want;
      n_beats++;
      if (due_q.size() == 0) begin
        n_fails++;
        if (n_fails <= 10) $display("ERROR: unexpected result: %s", show(got));
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        n_fails++;
        if (n_fails <= 10) begin
          $display("ERROR: result %0d differs at %0t", n_beats, $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== verif/h264_rtp_fu_packetizer_tb.sv =====
// Self-checking testbench for the H.264 RTP FU-A packetiser top level.
`timescale 1ns / 100ps

module h264_rtp_fu_packetizer_tb;
  import h264fu_pkg::*;
  import h264_rtp_fu_tb_pkg::*;

  localparam int CLK_HALF_NS = 5;
  localparam int TIMEOUT_NS  = 2_000_000;
  localparam int TAIL_CYCLES = 12;
  localparam int LONG_HOLD   = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_MTU;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = '0;
  logic                 in_nal_first = 1'b0;
  logic [LEN_W-1:0]     in_nal_length = '0;
  logic [STAMP_W-1:0]   in_stamp_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_packet_start;
  logic                 out_packet_end;
  logic [SEQ_W-1:0]     out_seq_number;
  logic                 out_marker_bit;
  logic [STAMP_W-1:0]   out_stamp_out;
  logic                 out_item_done;

  fu_packet_scoreboard sb;

  int current_mtu = 1400;
  int live_bytes = 0;
  int burst_left = 0;
  bit gap_free = 1'b0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int ready_pct = 100;

  h264_rtp_fu_packetizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_nal_first     (in_nal_first),
    .in_nal_length    (in_nal_length),
    .in_stamp_in      (in_stamp_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_packet_start (out_packet_start),
    .out_packet_end   (out_packet_end),
    .out_seq_number   (out_seq_number),
    .out_marker_bit   (out_marker_bit),
    .out_stamp_out    (out_stamp_out),
    .out_item_done    (out_item_done)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Receiver: checks each output transaction and stalls on its own pattern,
  // with a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    payload_beat_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.data      = out_byte;
      seen.pkt_start = out_packet_start;
      seen.pkt_end   = out_packet_end;
      seen.seq       = out_seq_number;
      seen.marker    = out_marker_bit;
      seen.stamp     = out_stamp_out;
      seen.item_last = out_item_done;
      sb.check_result(seen);
    end
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (rx_cycle % 40 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: ready_pct = 100;
        2: ready_pct = 75;
        3: ready_pct = 50;
        default: ready_pct = 25;
      endcase
    end
    rx_cycle++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Offers one byte and waits for its transaction; the sender then either
  // keeps valid high for the next byte or drops it for a random gap.
  task automatic send_byte(logic [7:0] d, logic first, logic [LEN_W-1:0] len,
                           logic [STAMP_W-1:0] stamp);
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_nal_first  <= first;
    in_nal_length <= len;
    in_stamp_in   <= stamp;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (sb.note_input(d, first, len, stamp) > 0) live_bytes++;
    if (!gap_free && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Header byte first, then n_send - 1 data bytes with junk in the ignored fields.
  task automatic send_unit(logic [7:0] hdr, logic [LEN_W-1:0] len, int n_send,
                           logic [STAMP_W-1:0] stamp);
    int i;
    send_byte(hdr, 1'b1, len, stamp);
    for (i = 1; i < n_send; i++) send_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
  endtask

  // Waits until the block has drained before the registers are touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] mtu_val, logic [CFG_W-1:0] seq_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_MTU;
    cfg_wdata <= mtu_val;
    @(posedge clk);
    sb.write_reg(CFG_IDX_MTU, mtu_val);
    cfg_index <= CFG_IDX_SEQ;
    cfg_wdata <= seq_val;
    @(posedge clk);
    sb.write_reg(CFG_IDX_SEQ, seq_val);
    cfg_we <= 1'b0;
    current_mtu = mtu_val;
  endtask

  // Mostly well-formed units with random content; some land on the MTU
  // boundary, some are cut short, and stray bytes and delimiters are mixed in.
  task automatic random_traffic(int target);
    int         pick;
    int         thresh;
    int         pay;
    int         len;
    int         n_send;
    logic [2:0] top;
    logic [4:0] nal_type;
    thresh = current_mtu - RTP_HDR_BYTES;
    pay = current_mtu - RTP_HDR_BYTES - FU_HDR_BYTES;
    while (live_bytes < target) begin
      top = 3'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: nal_type = 5'd1;
        4, 5: nal_type = 5'd5;
        6: nal_type = NAL_SPS;
        7: nal_type = NAL_PPS;
        8: nal_type = NAL_AUD;
        default: nal_type = 5'($urandom);
      endcase
      pick = $urandom_range(1, 100);
      if (pick <= 25 && thresh <= 300) len = thresh + 1 + $urandom_range(0, pay + 8);
      else if (pick <= 30 && thresh <= 300) len = thresh + $urandom_range(0, 1);
      else if (pick <= 34) len = 0;
      else if (pick <= 40) len = $urandom_range(1000, 65535);
      else len = $urandom_range(1, 16);
      if (len > 300) n_send = $urandom_range(1, 6);
      else if ($urandom_range(1, 10) == 1) n_send = $urandom_range(1, (len > 1) ? len - 1 : 1);
      else n_send = (len == 0) ? 1 : len;
      send_unit({top, nal_type}, LEN_W'(len), n_send, $urandom);
      if ($urandom_range(1, 10) == 1) begin
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset register values. Units before the first SPS,
    // delimiters and stray bytes are dropped; zero length, a cut-short unit,
    // a maximum-length unit that opens a fragment, and field extremes.
    send_unit(8'h41, 16'd2, 2, 32'h0000_0001);
    send_byte(8'h00, 1'b0, 16'h0000, 32'h0000_0000);
    send_unit(8'h67, 16'd0, 1, 32'hFFFF_FFFF);
    send_unit(8'h09, 16'd2, 2, 32'h5555_AAAA);
    send_unit(8'h68, 16'd3, 3, 32'h0000_0000);
    send_unit(8'hE5, 16'd4, 2, 32'h1234_5678);
    send_byte(8'h01, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b0, 16'h0000, 32'h0000_0000);
    send_byte(8'hA5, 1'b0, 16'h5A5A, 32'hA5A5_5A5A);
    send_byte(8'h61, 1'b1, 16'd3, 32'h8000_0000);
    send_byte(8'hFF, 1'b0, 16'd0, 32'd0);
    send_byte(8'h00, 1'b0, 16'd0, 32'd0);
    send_byte(8'h7E, 1'b0, 16'd9, 32'd9);
    send_unit(8'h27, 16'd1, 1, 32'h7FFF_FFFF);
    settle();

    // Smallest MTU with the sequence number close to wrapping.
    configure(16'd64, 16'd65533);
    live_bytes = 0;
    random_traffic(20);

    // Output held off for a long stretch while a fragmented unit is offered
    // back to back, so that the block fills up and stalls its input.
    hold_asked <= hold_asked + 1;
    gap_free = 1'b1;
    send_unit(8'h65, 16'd70, 70, $urandom);
    gap_free = 1'b0;
    settle();

    // Largest MTU: everything but the longest units goes out whole.
    configure(16'd9000, CFG_W'($urandom));
    live_bytes = 0;
    random_traffic(15);
    settle();

    configure(CFG_W'($urandom_range(64, 120)), 16'hFFFF);
    live_bytes = 0;
    random_traffic(20);
    settle();

    $display("Run covered %0d accepted bytes, %0d whole-unit packets and %0d FU-A fragments",
             sb.n_bytes, sb.n_whole, sb.n_frags);
    $display("with %0d result transactions checked over four MTU settings, %0d failures.",
             sb.n_beats, sb.n_fails);
    if (sb.n_fails == 0 && sb.due_q.size() == 0) begin
      $display("h264_rtp_fu_packetizer regression: pass");
    end else begin
      $display("h264_rtp_fu_packetizer regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still expected.", sb.due_q.size());
    $display("h264_rtp_fu_packetizer regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/h264fu_pkg.sv
sv/h264fu_front.sv
sv/h264fu_queue.sv
sv/h264fu_back.sv
sv/h264_rtp_fu_packetizer.sv
verif/h264_rtp_fu_tb_pkg.sv
verif/h264_rtp_fu_packetizer_tb.sv
